// ===== sv/epsmi_pkg.sv =====
package epsmi_pkg;

  localparam int MAX_VALUE_BYTES = 11;
  localparam int STORE_IW = $clog2(MAX_VALUE_BYTES);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_IEI   = 2'd2;
  localparam logic [1:0] ST_VALUE = 2'd3;

  localparam logic [2:0] KIND_IMSI = 3'd1;
  localparam logic [2:0] KIND_IMEI = 3'd3;
  localparam logic [2:0] KIND_GUTI = 3'd6;

  localparam logic [3:0] NIB_FILL = 4'hf;

  localparam logic [7:0] IMSI_MIN_LEN  = 8'd4;
  localparam logic [7:0] IMSI_MAX_USED = 8'd8;
  localparam logic [7:0] IMEI_LEN      = 8'd8;
  localparam logic [7:0] GUTI_LEN      = 8'd11;
  localparam logic [4:0] IMSI_MIN_DIG  = 5'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_buffer;
    logic       last_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  identity_kind;
    logic        odd_even_flag;
    logic [59:0] bcd_digits;
    logic [23:0] plmn_digits;
    logic [15:0] group_id;
    logic [7:0]  node_code;
    logic [31:0] temp_subscriber_id;
    logic [3:0]  bytes_consumed;
  } out_t;

  typedef logic [MAX_VALUE_BYTES-1:0][7:0] store_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_VAL1 = 5'b00100,
    PH_VAL2 = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

endpackage

// ===== sv/epsmi_decode.sv =====
module epsmi_decode (
  input  epsmi_pkg::store_t store,
  input  logic [7:0]        elem_len,
  input  logic              hdr2,
  output epsmi_pkg::out_t   res
);
  import epsmi_pkg::*;

  logic [7:0] b0;
  logic [2:0] kind;
  logic       odd;
  logic [3:0] used;
  logic [4:0] nd;
  logic [3:0] hdr;
  logic [3:0] dig [15];
  logic       bad;
  logic [59:0] bcd;

  always_comb begin
    b0   = store[0];
    kind = b0[2:0];
    odd  = b0[3];
    hdr  = hdr2 ? 4'd2 : 4'd1;
    if (kind == KIND_IMEI) begin
      used = 4'(IMEI_LEN);
    end else if (elem_len < IMSI_MAX_USED) begin
      used = elem_len[3:0];
    end else begin
      used = 4'(IMSI_MAX_USED);
    end
    nd = odd ? 5'({used, 1'b0} - 5'd1) : 5'({used, 1'b0} - 5'd2);

    // digit k comes from value byte (k+1)/2, low nibble for odd k
    dig[0] = b0[7:4];
    for (int k = 1; k < 15; k++) begin
      if (4'((k + 1) >> 1) < used) begin
        dig[k] = (k % 2 == 1) ? store[(k + 1) >> 1][3:0] : store[(k + 1) >> 1][7:4];
      end else begin
        dig[k] = NIB_FILL;
      end
    end

    bad = (nd < IMSI_MIN_DIG);
    for (int k = 0; k < 15; k++) begin
      if ((5'(k) < nd) && (dig[k] == NIB_FILL)) bad = 1'b1;
      // even count: the last high nibble is filler and must be 0xf
      if (!odd && (5'(k) == nd) && (dig[k] != NIB_FILL)) bad = 1'b1;
    end

    bcd = '0;
    for (int k = 0; k < 15; k++) begin
      bcd[4*k +: 4] = dig[k];
    end

    res = '0;
    if (elem_len == 8'd0) begin
      res.status = ST_SHORT;
    end else begin
      case (kind)
        KIND_IMSI: begin
          if (elem_len < IMSI_MIN_LEN) begin
            res.status = ST_SHORT;
          end else if (bad) begin
            res.status = ST_VALUE;
          end else begin
            res.status         = ST_OK;
            res.identity_kind  = kind;
            res.odd_even_flag  = odd;
            res.bcd_digits     = bcd;
            res.bytes_consumed = hdr + used;
          end
        end
        KIND_IMEI: begin
          if (elem_len < IMEI_LEN) begin
            res.status = ST_SHORT;
          end else begin
            res.status         = ST_OK;
            res.identity_kind  = kind;
            res.odd_even_flag  = odd;
            res.bcd_digits     = bcd;
            res.bytes_consumed = hdr + used;
          end
        end
        KIND_GUTI: begin
          if (elem_len < GUTI_LEN) begin
            res.status = ST_SHORT;
          end else if (b0[7:4] != NIB_FILL) begin
            res.status = ST_VALUE;
          end else begin
            res.status             = ST_OK;
            res.identity_kind      = kind;
            res.odd_even_flag      = odd;
            res.plmn_digits        = {store[2][7:4], store[3][7:4], store[3][3:0],
                                      store[2][3:0], store[1][7:4], store[1][3:0]};
            res.group_id           = {store[4], store[5]};
            res.node_code          = store[6];
            res.temp_subscriber_id = {store[7], store[8], store[9], store[10]};
            res.bytes_consumed     = hdr + 4'(GUTI_LEN);
          end
        end
        default: begin
          res.status = ST_VALUE;
        end
      endcase
    end
  end

endmodule

// ===== sv/epsmi_core.sv =====
module epsmi_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  epsmi_pkg::in_t  item,
  input  logic [7:0]      expected_iei,
  output logic            res_valid,
  output epsmi_pkg::out_t res
);
  import epsmi_pkg::*;

  phase_t     phase_r, phase_step, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  store_t     store_r, store_nxt;
  logic       active;
  logic       iei_fail;
  logic       hit;
  out_t       dec_res;

  always_comb begin
    phase_step = phase_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    store_nxt  = store_r;
    active     = 1'b0;
    iei_fail   = 1'b0;
    if (step_en) begin
      if (item.first_of_buffer) begin
        active  = 1'b1;
        cnt_nxt = '0;
        len_nxt = '0;
        if (expected_iei != 8'd0) begin
          if (item.data_byte != expected_iei) begin
            iei_fail = 1'b1;
          end else begin
            phase_step = PH_LEN;
          end
        end else begin
          len_nxt    = item.data_byte;
          phase_step = PH_VAL1;
        end
      end else begin
        case (phase_r)
          PH_LEN: begin
            active     = 1'b1;
            len_nxt    = item.data_byte;
            phase_step = PH_VAL2;
          end
          PH_VAL1, PH_VAL2: begin
            active = 1'b1;
            // bytes past the store are counted but dropped
            if (cnt_r < 8'(MAX_VALUE_BYTES)) begin
              store_nxt[cnt_r[STORE_IW-1:0]] = item.data_byte;
            end
            cnt_nxt = cnt_r + 8'd1;
          end
          default: ;
        endcase
      end
    end
  end

  epsmi_decode u_decode (
    .store    (store_nxt),
    .elem_len (len_nxt),
    .hdr2     (phase_step == PH_VAL2),
    .res      (dec_res)
  );

  assign hit = active && !iei_fail && (cnt_nxt == len_nxt) &&
               ((phase_step == PH_VAL1) || (phase_step == PH_VAL2));

  always_comb begin
    phase_nxt = phase_step;
    res_valid = 1'b0;
    res       = '0;
    if (iei_fail) begin
      res_valid  = 1'b1;
      res.status = ST_IEI;
      phase_nxt  = PH_DONE;
    end else if (hit) begin
      res_valid = 1'b1;
      res       = dec_res;
      phase_nxt = PH_DONE;
    end else if (active && item.last_of_buffer) begin
      res_valid  = 1'b1;
      res.status = ST_SHORT;
      phase_nxt  = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

// ===== sv/eps_mobile_identity_ie_parser.sv =====
// EPS mobile identity element parser. Takes one buffer byte per cycle on the in_ channel and
// gives at most one result per buffer on the out_ channel, on a mismatched IEI byte, on the
// byte that completes the value or on the last byte of a short buffer. Each byte passes an
// input register and then the per-byte state update and identity decode into the output
// register; the single state update per byte sets the rate of one byte per cycle, sustained
// while out_ready stays high. expected_iei is written through the cfg_ port, which is always
// ready, and is used on the first byte of each buffer.
module eps_mobile_identity_ie_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  epsmi_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output epsmi_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);
  import epsmi_pkg::*;

  logic       a_valid_r;
  in_t        a_data_r;
  logic       out_valid_r;
  out_t       out_data_r;
  logic [7:0] iei_r;
  logic       advance;
  logic       res_valid;
  out_t       res;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !a_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  epsmi_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (a_valid_r && advance),
    .item         (a_data_r),
    .expected_iei (iei_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iei_r       <= '0;
    end else begin
      if (in_ready) a_valid_r <= in_valid;
      if (advance) out_valid_r <= a_valid_r && res_valid;
      if (cfg_valid) iei_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) a_data_r <= in_data;
    if (advance) out_data_r <= res;
  end

  // a failed parse carries nothing but its status
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |->
      ((out_data_r.bytes_consumed == 4'd0) && (out_data_r.bcd_digits == '0) &&
       (out_data_r.identity_kind == 3'd0)))
    else $error("failed result carries field data");

  a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_OK)) |-> (out_data_r.bytes_consumed >= 4'd5))
    else $error("successful result with too few bytes consumed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

// ===== verif/identity_result_checker.sv =====
`timescale 1ns / 1ps

module identity_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  epsmi_pkg::in_t    in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  epsmi_pkg::out_t   out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output int                error_count,
  output int                pending_count
);
  import epsmi_pkg::*;

  logic [7:0] iei_cfg;
  phase_t     phase;
  logic [7:0] elem_len;
  logic [7:0] val_count;
  logic [7:0] val_store [MAX_VALUE_BYTES];
  out_t       expected_ids [$];
  int         errors;

  // decode of a complete value, from the bytes kept for the current buffer
  function automatic out_t decode_identity();
    out_t       r;
    logic [7:0] b0;
    logic [3:0] dig [15];
    int         used;
    int         nd;
    int         hdr;
    int         i;
    logic       bad;
    r = '0;
    hdr = (phase == PH_VAL2) ? 2 : 1;
    b0 = val_store[0];
    bad = 1'b0;
    used = 0;
    for (i = 0; i < 15; i++) dig[i] = NIB_FILL;
    if (elem_len == 8'd0) begin
      r.status = ST_SHORT;
      return r;
    end
    case (b0[2:0])
      KIND_IMSI: begin
        if (elem_len < IMSI_MIN_LEN) begin
          r.status = ST_SHORT;
          return r;
        end
        used = (elem_len < IMSI_MAX_USED) ? int'(elem_len) : int'(IMSI_MAX_USED);
        dig[0] = b0[7:4];
        for (i = 1; i < used; i++) begin
          dig[2 * i - 1] = val_store[i][3:0];
          dig[2 * i] = val_store[i][7:4];
        end
        nd = 2 * used - 1;
        // even digit count: the last high nibble is filler
        if (!b0[3]) begin
          if (dig[nd - 1] != NIB_FILL) bad = 1'b1;
          nd--;
        end
        if (nd < int'(IMSI_MIN_DIG)) bad = 1'b1;
        for (i = 0; i < nd; i++) begin
          if (dig[i] == NIB_FILL) bad = 1'b1;
        end
        if (bad) begin
          r.status = ST_VALUE;
          return r;
        end
      end
      KIND_IMEI: begin
        if (elem_len < IMEI_LEN) begin
          r.status = ST_SHORT;
          return r;
        end
        used = int'(IMEI_LEN);
        dig[0] = b0[7:4];
        for (i = 1; i < used; i++) begin
          dig[2 * i - 1] = val_store[i][3:0];
          dig[2 * i] = val_store[i][7:4];
        end
      end
      KIND_GUTI: begin
        if (elem_len < GUTI_LEN) begin
          r.status = ST_SHORT;
          return r;
        end
        if (b0[7:4] != NIB_FILL) begin
          r.status = ST_VALUE;
          return r;
        end
        r.status = ST_OK;
        r.identity_kind = b0[2:0];
        r.odd_even_flag = b0[3];
        // mnc3 sits in the high nibble of the second plmn octet
        r.plmn_digits = {val_store[2][7:4], val_store[3][7:4], val_store[3][3:0],
                         val_store[2][3:0], val_store[1][7:4], val_store[1][3:0]};
        r.group_id = {val_store[4], val_store[5]};
        r.node_code = val_store[6];
        r.temp_subscriber_id = {val_store[7], val_store[8], val_store[9], val_store[10]};
        r.bytes_consumed = 4'(hdr + int'(GUTI_LEN));
        return r;
      end
      default: begin
        r.status = ST_VALUE;
        return r;
      end
    endcase
    r.status = ST_OK;
    r.identity_kind = b0[2:0];
    r.odd_even_flag = b0[3];
    for (i = 0; i < 15; i++) r.bcd_digits[4 * i +: 4] = dig[i];
    r.bytes_consumed = 4'(hdr + used);
    return r;
  endfunction

  task automatic take_byte(input in_t b);
    out_t r;
    logic done_now;
    r = '0;
    done_now = 1'b0;
    if (b.first_of_buffer) begin
      val_count = 8'd0;
      elem_len = 8'd0;
      if (iei_cfg != 8'd0) begin
        if (b.data_byte != iei_cfg) begin
          r.status = ST_IEI;
          done_now = 1'b1;
        end else begin
          phase = PH_LEN;
        end
      end else begin
        elem_len = b.data_byte;
        phase = PH_VAL1;
      end
    end else if (phase == PH_LEN) begin
      elem_len = b.data_byte;
      phase = PH_VAL2;
    end else if (phase == PH_VAL1 || phase == PH_VAL2) begin
      if (val_count < MAX_VALUE_BYTES) val_store[val_count[STORE_IW-1:0]] = b.data_byte;
      val_count = val_count + 8'd1;
    end else begin
      return;  // outside a buffer
    end
    if (!done_now && (phase == PH_VAL1 || phase == PH_VAL2) && val_count == elem_len) begin
      r = decode_identity();
      done_now = 1'b1;
    end
    if (!done_now && b.last_of_buffer) begin
      r = '0;
      r.status = ST_SHORT;
      done_now = 1'b1;
    end
    if (done_now) begin
      phase = PH_DONE;
      expected_ids.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      iei_cfg = 8'd0;
      phase = PH_IDLE;
      elem_len = 8'd0;
      val_count = 8'd0;
      for (int i = 0; i < MAX_VALUE_BYTES; i++) val_store[i] = 8'd0;
      expected_ids.delete();
    end else begin
      if (cfg_valid && cfg_ready) iei_cfg = cfg_data;
      if (in_valid && in_ready) take_byte(in_data);
      if (out_valid && out_ready) begin
        if (expected_ids.size() == 0) begin
          $display("%0t: result transfer with nothing expected, expected none, got %h",
                   $time, out_data);
          errors++;
        end else begin
          want = expected_ids.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("identity_kind", 64'(want.identity_kind), 64'(out_data.identity_kind));
          check_field("odd_even_flag", 64'(want.odd_even_flag), 64'(out_data.odd_even_flag));
          check_field("bcd_digits", 64'(want.bcd_digits), 64'(out_data.bcd_digits));
          check_field("plmn_digits", 64'(want.plmn_digits), 64'(out_data.plmn_digits));
          check_field("group_id", 64'(want.group_id), 64'(out_data.group_id));
          check_field("node_code", 64'(want.node_code), 64'(out_data.node_code));
          check_field("temp_subscriber_id", 64'(want.temp_subscriber_id),
                      64'(out_data.temp_subscriber_id));
          check_field("bytes_consumed", 64'(want.bytes_consumed),
                      64'(out_data.bytes_consumed));
        end
      end
    end
    error_count <= errors;
    pending_count <= expected_ids.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import epsmi_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int PHASE_ITEMS = 92;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int         error_count;
  int         pending_count;
  int         cycle_count;
  int         in_gap_pct;
  int         out_stall_pct;
  int         sent_items;
  logic [7:0] iei_now;
  logic [7:0] buf_q [$];
  logic [7:0] iei_plan [6];

  eps_mobile_identity_ie_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  identity_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // valid stays up between back-to-back bytes; it only drops during a gap
  task automatic drive_byte(input logic [7:0] d, input logic f, input logic l);
    in_t b;
    b.data_byte = d;
    b.first_of_buffer = f;
    b.last_of_buffer = l;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_buf(input logic mark_last);
    int i;
    for (i = 0; i < buf_q.size(); i++) begin
      drive_byte(buf_q[i], i == 0, mark_last && i == buf_q.size() - 1);
    end
    sent_items += buf_q.size();
  endtask

  // expected_iei only changes with the parser drained
  task automatic write_iei(input logic [7:0] v);
    in_valid <= 1'b0;
    repeat (8) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iei_now = v;
  endtask

  task automatic send_random_element();
    logic [7:0] val [$];
    logic [3:0] dig [15];
    logic [3:0] hi;
    logic       odd;
    int         n;
    int         i;
    int         len_field;
    val = {};
    case ($urandom_range(9))
      0, 1, 2: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 1) : $urandom_range(15, 6);
        for (i = 0; i < 15; i++) dig[i] = 4'($urandom_range(9));
        if ($urandom_range(9) == 0) dig[$urandom_range(n - 1)] = NIB_FILL;
        odd = n[0];
        if ($urandom_range(11) == 0) odd = ~odd;
        val.push_back({dig[0], odd, KIND_IMSI});
        for (i = 1; 2 * i - 1 < n; i++) begin
          hi = (2 * i < n) ? dig[2 * i] : NIB_FILL;
          if (2 * i >= n && $urandom_range(7) == 0) hi = 4'($urandom_range(15));
          val.push_back({hi, dig[2 * i - 1]});
        end
      end
      3, 4: begin
        odd = ($urandom_range(7) != 0);
        val.push_back({4'($urandom_range(15)), odd, KIND_IMEI});
        repeat (7) val.push_back(8'($urandom));
      end
      5, 6, 7: begin
        hi = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : NIB_FILL;
        val.push_back({hi, 1'($urandom_range(1)), KIND_GUTI});
        repeat (10) val.push_back(8'($urandom));
      end
      default: begin
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
        repeat (n) val.push_back(8'($urandom));
      end
    endcase
    case ($urandom_range(9))
      0: begin
        n = $urandom_range(val.size(), 1);
        while (val.size() > n) void'(val.pop_back());
      end
      1: repeat ($urandom_range(4, 1)) val.push_back(8'($urandom));
      default: ;
    endcase
    len_field = val.size();
    if ($urandom_range(9) == 0) len_field = $urandom_range(val.size() + 3, 0);
    buf_q = {};
    if (iei_now != 8'd0) buf_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : iei_now);
    buf_q.push_back(8'(len_field));
    foreach (val[k]) buf_q.push_back(val[k]);
    case ($urandom_range(19))
      0: begin  // buffer cut to a random length that may end before the value
        n = $urandom_range(buf_q.size(), 1);
        while (buf_q.size() > n) void'(buf_q.pop_back());
        send_buf(1'b1);
      end
      1: begin  // abandoned, the next first byte restarts the parse
        n = $urandom_range(buf_q.size(), 1);
        while (buf_q.size() > n) void'(buf_q.pop_back());
        send_buf(1'b0);
      end
      2: send_buf(1'b0);
      3: begin  // trailing bytes after the result are dropped
        send_buf(1'b1);
        repeat ($urandom_range(3, 1)) drive_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end
      default: send_buf(1'b1);
    endcase
  endtask

  initial begin
    int ph;
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 8'd0;
    iei_now = 8'd0;
    sent_items = 0;
    in_gap_pct = 10;
    out_stall_pct = 87;
    iei_plan = '{8'hff, 8'h00, 8'h01, 8'ha7, 8'h00, 8'hff};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_iei(8'h00);
    drive_byte(8'h5a, 1'b0, 1'b0);
    buf_q = {8'h00};
    send_buf(1'b1);
    buf_q = {8'h05};
    send_buf(1'b1);
    buf_q = {8'h04, 8'h11, 8'h32, 8'h54, 8'hf6};
    send_buf(1'b1);
    buf_q = {8'h0b, 8'hfe, 8'h00, 8'hff, 8'h21, 8'hff, 8'h00, 8'h80, 8'h01, 8'hff, 8'h7f,
             8'h00};
    send_buf(1'b1);
    buf_q = {8'h08, 8'h33};
    send_buf(1'b0);
    buf_q = {8'h01, 8'h07};
    send_buf(1'b1);

    for (ph = 0; ph < 6; ph++) begin
      in_gap_pct = (ph < 2) ? 10 : (ph < 4) ? 87 : 0;
      out_stall_pct = (ph < 2) ? 87 : (ph < 4) ? 10 : 0;
      write_iei(iei_plan[ph]);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) send_random_element();
    end

    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== eps_mobile_identity_ie_parser.f =====
sv/epsmi_pkg.sv
sv/epsmi_decode.sv
sv/epsmi_core.sv
sv/eps_mobile_identity_ie_parser.sv
verif/identity_result_checker.sv
verif/testbench.sv
